// ===== hw/rtl/gfrd_pkg.sv =====
package gfrd_pkg;

    localparam logic [7:0] BYTE_START      = 8'h0D;
    localparam logic [7:0] BYTE_END        = 8'h0A;
    localparam logic [7:0] BYTE_DISCONNECT = 8'hAB;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [7:0]  AXIS_X_RESET   = 8'd128;
    localparam logic [7:0]  AXIS_Y_RESET   = 8'd127;

    // only the button and axis bytes of a frame are ever unpacked
    localparam int FRAME_SLOTS = 6;

    localparam logic [0:0] ADDR_DEBOUNCE_TIME = 1'b0;

    typedef enum logic [1:0] {
        MODE_BYTE        = 2'd0,
        MODE_TICK        = 2'd1,
        MODE_CLR_PRESS   = 2'd2,
        MODE_CLR_RELEASE = 2'd3
    } t_mode;

    typedef struct packed {
        logic [15:0] stable_buttons;
        logic [15:0] pressed_pending;
        logic [15:0] released_pending;
        logic [15:0] changed_mask;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic        frame_done;
        logic        link_up;
        logic        event_hit;
    } t_result;

endpackage

// ===== hw/rtl/gamepad_frame_receiver_debounce.sv =====
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// input    | i_in_valid / o_in_ready    | i_mode, i_rx_byte, i_button_mask
// result   | o_out_valid / i_out_ready  | o_stable_buttons .. o_event_hit
// config   | psel penable pwrite pready | paddr, pwdata, prdata (debounce_time)
//
// one word per cycle while o_in_ready is high: state is updated and the result registered at the accept edge,
// into the main entry, or into the skid entry while the main entry is stalled
// a two-entry output register (main plus skid) keeps input flowing while the
// result side stalls; o_in_ready drops only when both entries are full
// synchronous active-low reset sets all state but the output data entries; debounce_time returns to 30
module gamepad_frame_receiver_debounce #(
    parameter int BUFFER_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_rx_byte,
    input  logic [15:0] i_button_mask,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_stable_buttons,
    output logic [15:0] o_pressed_pending,
    output logic [15:0] o_released_pending,
    output logic [15:0] o_changed_mask,
    output logic [7:0]  o_left_x,
    output logic [7:0]  o_left_y,
    output logic [7:0]  o_right_x,
    output logic [7:0]  o_right_y,
    output logic        o_frame_done,
    output logic        o_link_up,
    output logic        o_event_hit,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gfrd_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_DEPTH - 1);

    logic [15:0]      r_debounce_time;
    logic             r_receiving, n_receiving;
    logic             r_ignoring, n_ignoring;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_store [FRAME_SLOTS];
    logic [7:0]       n_store [FRAME_SLOTS];
    logic [15:0]      r_raw, n_raw;
    logic [15:0]      r_stable, n_stable;
    logic [15:0]      r_prev, n_prev;
    logic [15:0]      r_press, n_press;
    logic [15:0]      r_release, n_release;
    logic [15:0]      r_elapsed, n_elapsed;
    logic [7:0]       r_lx, n_lx, r_ly, n_ly, r_rx, n_rx, r_ry, n_ry;

    t_result          r_out, r_skid, w_res;
    logic             r_out_valid, r_skid_valid;
    logic             w_accept, w_take, w_done, w_hit;
    logic [15:0]      w_frame_raw, w_hits;
    t_mode            w_mode;

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_DEBOUNCE_TIME) ? {16'd0, r_debounce_time} : 32'd0;

    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_take     = r_out_valid && i_out_ready;
    assign w_mode     = t_mode'(i_mode);

    always_comb begin
        n_receiving = r_receiving;
        n_ignoring  = r_ignoring;
        n_idx       = r_idx;
        n_store     = r_store;
        n_raw       = r_raw;
        n_stable    = r_stable;
        n_prev      = r_prev;
        n_press     = r_press;
        n_release   = r_release;
        n_elapsed   = r_elapsed;
        n_lx        = r_lx;
        n_ly        = r_ly;
        n_rx        = r_rx;
        n_ry        = r_ry;
        w_done      = 1'b0;
        w_hit       = 1'b0;
        w_hits      = 16'd0;
        w_frame_raw = 16'd0;

        case (w_mode)
            MODE_BYTE: begin
                if (i_rx_byte == BYTE_DISCONNECT) begin
                    n_receiving = 1'b0;
                    n_idx       = '0;
                    n_ignoring  = 1'b1;
                end else if (r_ignoring) begin
                    if (i_rx_byte == BYTE_START) begin
                        n_ignoring  = 1'b0;
                        n_receiving = 1'b1;
                        n_idx       = '0;
                    end
                end else if (r_receiving) begin
                    // the closing byte lands in the store too (if its index is below FRAME_SLOTS), before unpacking
                    for (int k = 0; k < FRAME_SLOTS; k++) begin
                        if (r_idx == IDX_W'(k)) begin
                            n_store[k] = i_rx_byte;
                        end
                    end
                    if (i_rx_byte != BYTE_END) begin
                        n_idx = (r_idx == IDX_LAST) ? r_idx : r_idx + 1'b1;
                    end else begin
                        n_receiving = 1'b0;
                        n_idx       = '0;
                        w_done      = 1'b1;
                        w_frame_raw = {n_store[0], n_store[1]};
                        n_ly        = n_store[2];
                        n_lx        = n_store[3];
                        n_ry        = n_store[4];
                        n_rx        = n_store[5];
                        if (w_frame_raw != r_raw) begin
                            n_raw     = w_frame_raw;
                            n_elapsed = 16'd0;
                        end else if (r_elapsed >= r_debounce_time
                                     && r_stable != w_frame_raw) begin
                            n_prev    = r_stable;
                            n_stable  = w_frame_raw;
                            n_press   = r_press | (w_frame_raw & ~r_stable);
                            n_release = r_release | (r_stable & ~w_frame_raw);
                        end
                    end
                end else if (i_rx_byte == BYTE_START) begin
                    n_receiving = 1'b1;
                    n_idx       = '0;
                end
            end
            MODE_TICK: begin
                if (r_elapsed != 16'hFFFF) begin
                    n_elapsed = r_elapsed + 16'd1;
                end
            end
            MODE_CLR_PRESS: begin
                w_hits  = r_press & i_button_mask;
                w_hit   = (w_hits != 16'd0);
                n_press = r_press & ~w_hits;
            end
            MODE_CLR_RELEASE: begin
                w_hits    = r_release & i_button_mask;
                w_hit     = (w_hits != 16'd0);
                n_release = r_release & ~w_hits;
            end
            default: begin
            end
        endcase

        w_res.stable_buttons   = n_stable;
        w_res.pressed_pending  = n_press;
        w_res.released_pending = n_release;
        w_res.changed_mask     = n_prev ^ n_stable;
        w_res.left_x           = n_lx;
        w_res.left_y           = n_ly;
        w_res.right_x          = n_rx;
        w_res.right_y          = n_ry;
        w_res.frame_done       = w_done;
        w_res.link_up          = !n_ignoring;
        w_res.event_hit        = w_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time <= DEBOUNCE_RESET;
            r_receiving     <= 1'b0;
            r_ignoring      <= 1'b0;
            r_idx           <= '0;
            for (int k = 0; k < FRAME_SLOTS; k++) begin
                r_store[k] <= 8'd0;
            end
            r_raw           <= 16'd0;
            r_stable        <= 16'd0;
            r_prev          <= 16'd0;
            r_press         <= 16'd0;
            r_release       <= 16'd0;
            r_elapsed       <= 16'd0;
            r_lx            <= AXIS_X_RESET;
            r_ly            <= AXIS_Y_RESET;
            r_rx            <= AXIS_X_RESET;
            r_ry            <= AXIS_Y_RESET;
            r_out_valid     <= 1'b0;
            r_skid_valid    <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == ADDR_DEBOUNCE_TIME) begin
                r_debounce_time <= pwdata[15:0];
            end
            if (w_accept) begin
                r_receiving <= n_receiving;
                r_ignoring  <= n_ignoring;
                r_idx       <= n_idx;
                r_store     <= n_store;
                r_raw       <= n_raw;
                r_stable    <= n_stable;
                r_prev      <= n_prev;
                r_press     <= n_press;
                r_release   <= n_release;
                r_elapsed   <= n_elapsed;
                r_lx        <= n_lx;
                r_ly        <= n_ly;
                r_rx        <= n_rx;
                r_ry        <= n_ry;
            end
            // main entry drains first; skid only fills while main is stalled
            if (w_take) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else if (w_accept) begin
                    r_out <= w_res;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (w_accept) begin
                if (r_out_valid) begin
                    r_skid       <= w_res;
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out       <= w_res;
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_stable_buttons   = r_out.stable_buttons;
    assign o_pressed_pending  = r_out.pressed_pending;
    assign o_released_pending = r_out.released_pending;
    assign o_changed_mask     = r_out.changed_mask;
    assign o_left_x           = r_out.left_x;
    assign o_left_y           = r_out.left_y;
    assign o_right_x          = r_out.right_x;
    assign o_right_y          = r_out.right_y;
    assign o_frame_done       = r_out.frame_done;
    assign o_link_up          = r_out.link_up;
    assign o_event_hit        = r_out.event_hit;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a main entry");

    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mode == MODE_TICK) |=> (r_elapsed != 16'd0))
        else $error("tick left debounce counter at zero");

    a_disconnect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mode == MODE_BYTE && i_rx_byte == BYTE_DISCONNECT)
        |=> (r_ignoring && !r_receiving && r_idx == '0))
        else $error("disconnect byte did not drop the frame");

    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_done) |=> (!r_receiving && r_out_valid))
        else $error("closed frame left receiver open");

endmodule
